### rtl/core/ps2mt_pkg.sv
// shared types and constants for the ps/2 mouse packet tracker
`default_nettype none

package ps2mt_pkg;

    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int COUNT_BITS_DEFAULT    = 32;

    localparam int POS_OUT_BITS   = 32;
    localparam int COUNT_OUT_BITS = 32;
    localparam int BYTE_BITS      = 8;
    localparam int DY_OUT_BITS    = 9;

    localparam logic [BYTE_BITS-1:0] SYNC_MASK     = 8'h08;
    localparam logic [BYTE_BITS-1:0] OVERFLOW_MASK = 8'hC0;

    localparam int LEFT_BIT   = 0;
    localparam int RIGHT_BIT  = 1;
    localparam int MIDDLE_BIT = 2;

    typedef struct packed {
        logic                 left;
        logic                 right;
        logic                 middle;
        logic [BYTE_BITS-1:0] x_byte;
        logic [BYTE_BITS-1:0] y_byte;
    } packet_t;

endpackage

`default_nettype wire

### rtl/core/ps2mt_framer.sv
// byte framing: sync on header, collect three-byte packets, drop overflow packets
`default_nettype none

module ps2mt_framer
    import ps2mt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [BYTE_BITS-1:0] s_rx_byte,
    output logic                      pkt_valid,
    input  wire logic                 pkt_ready,
    output packet_t                   pkt
);

    localparam logic [1:0] POS_HEADER = 2'd0;
    localparam logic [1:0] POS_X      = 2'd1;
    localparam logic [1:0] POS_Y      = 2'd2;

    logic [1:0]           pos_reg, pos_next;
    logic [BYTE_BITS-1:0] header_reg, header_next;
    logic [BYTE_BITS-1:0] xbyte_reg, xbyte_next;
    logic                 pkt_valid_reg, pkt_valid_next;
    packet_t              pkt_reg, pkt_next;
    logic                 byte_xfer;

    assign s_ready   = !pkt_valid_reg || pkt_ready;
    assign byte_xfer = s_valid && s_ready;
    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

    always_comb begin
        pos_next       = pos_reg;
        header_next    = header_reg;
        xbyte_next     = xbyte_reg;
        pkt_next       = pkt_reg;
        pkt_valid_next = pkt_valid_reg && !pkt_ready;
        if (byte_xfer) begin
            unique case (pos_reg)
                POS_HEADER: begin
                    if ((s_rx_byte & SYNC_MASK) != '0) begin
                        header_next = s_rx_byte;
                        pos_next    = POS_X;
                    end
                end
                POS_X: begin
                    xbyte_next = s_rx_byte;
                    pos_next   = POS_Y;
                end
                default: begin
                    // third byte, also covers the unused position code
                    pos_next = POS_HEADER;
                    if ((header_reg & OVERFLOW_MASK) == '0) begin
                        pkt_valid_next  = 1'b1;
                        pkt_next.left   = header_reg[LEFT_BIT];
                        pkt_next.right  = header_reg[RIGHT_BIT];
                        pkt_next.middle = header_reg[MIDDLE_BIT];
                        pkt_next.x_byte = xbyte_reg;
                        pkt_next.y_byte = s_rx_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_HEADER;
            pkt_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            pkt_valid_reg <= pkt_valid_next;
        end
        header_reg <= header_next;
        xbyte_reg  <= xbyte_next;
        pkt_reg    <= pkt_next;
    end

endmodule

`default_nettype wire

### rtl/core/ps2mt_accum.sv
// position accumulators, packet counter and result register
`default_nettype none

module ps2mt_accum
    import ps2mt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int COUNT_BITS    = COUNT_BITS_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        pkt_valid,
    output logic                             pkt_ready,
    input  wire packet_t                     pkt,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [POS_OUT_BITS-1:0]   m_pos_x,
    output logic signed [POS_OUT_BITS-1:0]   m_pos_y,
    output logic                             m_left_pressed,
    output logic                             m_right_pressed,
    output logic                             m_middle_pressed,
    output logic        [COUNT_OUT_BITS-1:0] m_packets_seen,
    output logic signed [BYTE_BITS-1:0]      m_cursor_dx,
    output logic signed [DY_OUT_BITS-1:0]    m_cursor_dy
);

    logic signed [POSITION_BITS-1:0] x_total_reg, x_total_next;
    logic signed [POSITION_BITS-1:0] y_total_reg, y_total_next;
    logic        [COUNT_BITS-1:0]    count_reg, count_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            left_reg, right_reg, middle_reg;
    logic signed [BYTE_BITS-1:0]     dx_reg;
    logic signed [DY_OUT_BITS-1:0]   dy_reg;
    logic signed [POSITION_BITS-1:0] dx_ext, dy_ext;
    logic                            pkt_xfer;

    assign pkt_ready = !m_valid_reg || m_ready;
    assign pkt_xfer  = pkt_valid && pkt_ready;

    assign dx_ext = {{(POSITION_BITS-BYTE_BITS){pkt.x_byte[BYTE_BITS-1]}}, pkt.x_byte};
    assign dy_ext = {{(POSITION_BITS-BYTE_BITS){pkt.y_byte[BYTE_BITS-1]}}, pkt.y_byte};

    always_comb begin
        x_total_next = x_total_reg;
        y_total_next = y_total_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (pkt_xfer) begin
            x_total_next = x_total_reg + dx_ext;
            y_total_next = y_total_reg + dy_ext;
            count_next   = count_reg + COUNT_BITS'(1);
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_total_reg <= '0;
            y_total_reg <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            x_total_reg <= x_total_next;
            y_total_reg <= y_total_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        if (pkt_xfer) begin
            left_reg   <= pkt.left;
            right_reg  <= pkt.right;
            middle_reg <= pkt.middle;
            dx_reg     <= pkt.x_byte;
            dy_reg     <= DY_OUT_BITS'(0) - {pkt.y_byte[BYTE_BITS-1], pkt.y_byte};
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pos_x          = POS_OUT_BITS'(x_total_reg);
    assign m_pos_y          = POS_OUT_BITS'(y_total_reg);
    assign m_packets_seen   = COUNT_OUT_BITS'(count_reg);
    assign m_left_pressed   = left_reg;
    assign m_right_pressed  = right_reg;
    assign m_middle_pressed = middle_reg;
    assign m_cursor_dx      = dx_reg;
    assign m_cursor_dy      = dy_reg;

endmodule

`default_nettype wire

### rtl/core/ps2_mouse_packet_tracker.sv
// top level of the ps/2 mouse packet tracker
// usage:
//   s_ channel carries one byte of the mouse stream per transfer (s_rx_byte).
//   a byte with bit 3 clear is skipped while waiting for a header; the header,
//   the x byte and the y byte make up one packet.
//   a packet whose header has an overflow bit set gives no result; any other
//   packet updates the x/y position sums and the packet count and gives one
//   transfer on the m_ channel with position, buttons, count and cursor move.
//   the result shows on m_valid once the third byte's transfer has passed
//   through the framer's packet register and then the result register.
//   throughput: one byte per cycle while s_ready is high, set by the framer
//   step and the accumulator add; both stages hold a full register.
//   when the receiver stalls, the result holds, one more packet waits in the
//   framer register and then s_ready drops until the result is taken.
//   reset (aresetn low, synchronous) clears the byte position, the position
//   sums, the packet count and both valid flags.
`default_nettype none

module ps2_mouse_packet_tracker
    import ps2mt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int COUNT_BITS    = COUNT_BITS_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [BYTE_BITS-1:0]        s_rx_byte,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [POS_OUT_BITS-1:0]   m_pos_x,
    output logic signed [POS_OUT_BITS-1:0]   m_pos_y,
    output logic                             m_left_pressed,
    output logic                             m_right_pressed,
    output logic                             m_middle_pressed,
    output logic        [COUNT_OUT_BITS-1:0] m_packets_seen,
    output logic signed [BYTE_BITS-1:0]      m_cursor_dx,
    output logic signed [DY_OUT_BITS-1:0]    m_cursor_dy
);

    logic    pkt_valid;
    logic    pkt_ready;
    packet_t pkt;

    ps2mt_framer u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt)
    );

    ps2mt_accum #(
        .POSITION_BITS (POSITION_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_accum (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .pkt_valid        (pkt_valid),
        .pkt_ready        (pkt_ready),
        .pkt              (pkt),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pos_x          (m_pos_x),
        .m_pos_y          (m_pos_y),
        .m_left_pressed   (m_left_pressed),
        .m_right_pressed  (m_right_pressed),
        .m_middle_pressed (m_middle_pressed),
        .m_packets_seen   (m_packets_seen),
        .m_cursor_dx      (m_cursor_dx),
        .m_cursor_dy      (m_cursor_dy)
    );

    // a waiting packet holds until the accumulator takes it
    a_pkt_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt))
        else $error("packet changed while stalled");

    // every packet transfer bumps the count by exactly one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        pkt_valid && pkt_ready |=>
            m_packets_seen == $past(m_packets_seen) + COUNT_OUT_BITS'(1))
        else $error("packet count did not step");

    // sums and count move only on a packet transfer
    a_sums_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pkt_valid && pkt_ready) |=>
            $stable(m_pos_x) && $stable(m_pos_y) && $stable(m_packets_seen))
        else $error("sums moved without a packet");

    // a fresh result always comes with a new count
    a_result_new: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> m_packets_seen != $past(m_packets_seen))
        else $error("result without a counted packet");

endmodule

`default_nettype wire
